// ===== hdl/ffpa_pkg.sv =====
// shared types, constants and the waste function for the first-fit partition allocator
// no dependencies
`timescale 1ns / 1ps

package ffpa_pkg;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_FREE    = 2'd1;
    localparam logic [1:0] REQ_COMPACT = 2'd2;
    localparam logic [1:0] REQ_QUERY   = 2'd3;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_BAD_SIZE = 3'd1;
    localparam logic [2:0] ERR_SHORT    = 3'd2;
    localparam logic [2:0] ERR_DUP      = 3'd3;
    localparam logic [2:0] ERR_NO_FIT   = 3'd4;
    localparam logic [2:0] ERR_NOT_FND  = 3'd5;
    localparam logic [2:0] ERR_FULL     = 3'd6;
    localparam logic [2:0] ERR_FIXED    = 3'd7;

    localparam logic [1:0] CFG_TOTAL = 2'd0;
    localparam logic [1:0] CFG_MODE  = 2'd1;
    localparam logic [1:0] CFG_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  owner_id;
        logic [12:0] req_size;
    } req_t;

    typedef struct packed {
        logic        ok;
        logic [2:0]  error_code;
        logic [11:0] block_start;
        logic [12:0] waste_total;
        logic [12:0] hole_total;
        logic [12:0] free_total;
    } rsp_t;

    // size minus floor(size*7/10), size up to 4096
    function automatic logic [12:0] frag_of(input logic [12:0] s);
        logic [25:0] p;
        logic [12:0] q;
        begin
            p = 26'(s) * 26'd7;
            // divide by 10 via reciprocal 6554/65536 and one correction
            q = 13'((36'(p) * 36'd6554) >> 16);
            if (26'(q) * 26'd10 > p)
                q = q - 13'd1;
            frag_of = s - q;
        end
    endfunction

endpackage

// ===== hdl/ffpa_div.sv =====
// restoring divider for partition size, one quotient bit per cycle
// depends on nothing
`timescale 1ns / 1ps

module ffpa_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [12:0] dividend,
    input  logic [5:0]  divisor,
    output logic        busy,
    output logic [12:0] quotient
);
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic [12:0] q_reg;
    logic [6:0]  r_reg;
    logic [5:0]  d_reg;
    logic [7:0]  trial;

    assign trial = {r_reg, q_reg[12]} - {2'b00, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'd0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'd12)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg <= dividend;
            r_reg <= 7'd0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[7])
            begin
                r_reg <= trial[6:0];
                q_reg <= {q_reg[11:0], 1'b1};
            end
            else
            begin
                r_reg <= {r_reg[5:0], q_reg[12]};
                q_reg <= {q_reg[11:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;
endmodule

// ===== hdl/first_fit_partition_allocator.sv =====
// top level: block table, sequencer and result register of the allocator
// depends on ffpa_pkg and ffpa_div
`timescale 1ns / 1ps

// After a request is accepted, busy stays high while the sequencer walks the
// block table one entry per cycle: a query or a compact makes one pass over
// the table, an allocate runs an owner scan and then a first-fit scan (plus a
// shift per entry above a split), and a free in dynamic mode shifts entries
// down once for each merge, up to two. done is high for a single cycle with
// the result on rsp and cannot be stalled; busy is already low in that cycle.
// A configuration write rebuilds the table: a division for the partition size,
// then in fixed mode one entry per cycle, during which busy is high.
module first_fit_partition_allocator #(
    parameter int MAX_BLOCKS = 32,
    parameter int ID_BITS    = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  ffpa_pkg::req_t  req,
    output logic            done,
    output ffpa_pkg::rsp_t  rsp,
    input  logic            cfg_we,
    input  logic [1:0]      cfg_index,
    input  logic [12:0]     cfg_data
);
    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_BUILD = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_FIT   = 4'd4;
    localparam logic [3:0] S_OPEN  = 4'd5;
    localparam logic [3:0] S_RMV   = 4'd6;
    localparam logic [3:0] S_MERGE = 4'd7;
    localparam logic [3:0] S_COMP  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_DIVGO = 4'd10;

    // table entries held in flip-flops, each read at sequencer indices
    logic [11:0]        st_reg [MAX_BLOCKS];
    logic [12:0]        sz_reg [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] used_reg;
    logic [ID_BITS-1:0] own_reg [MAX_BLOCKS];

    logic [12:0]  total_reg;
    logic         mode_reg;
    logic [5:0]   count_reg;
    logic [CW-1:0] bcnt_reg;
    logic [12:0]  avail_reg;
    logic [3:0]   state_reg;
    logic [CW-1:0] i_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] k_reg;
    logic [12:0]  addr_reg;
    logic [12:0]  acc_reg;
    logic [1:0]   kind_reg;
    logic [ID_BITS-1:0] who_reg;
    logic [12:0]  want_reg;
    logic         merge2_reg;
    logic         done_reg;
    ffpa_pkg::rsp_t rsp_reg;

    logic [12:0] tot_c;
    logic [5:0]  cnt_c;
    logic        div_busy;
    logic [12:0] part;
    logic [IW-1:0] ix;
    logic [2:0]  early_err;
    ffpa_pkg::rsp_t rsp_init;

    always_comb
    begin
        tot_c = (total_reg == 13'd0) ? 13'd1 : (total_reg > 13'd4096 ? 13'd4096 : total_reg);
        cnt_c = (count_reg == 6'd0) ? 6'd1 :
                ({26'd0, count_reg} > MAX_BLOCKS ? 6'(MAX_BLOCKS) : count_reg);
        // checks that finish a request without a table walk
        early_err = ffpa_pkg::ERR_NONE;
        if (req.req_type == ffpa_pkg::REQ_ALLOC && req.req_size == 13'd0)
            early_err = ffpa_pkg::ERR_BAD_SIZE;
        else if (req.req_type == ffpa_pkg::REQ_ALLOC && req.req_size > avail_reg)
            early_err = ffpa_pkg::ERR_SHORT;
        else if (req.req_type == ffpa_pkg::REQ_COMPACT && !mode_reg)
            early_err = ffpa_pkg::ERR_FIXED;
        rsp_init = '0;
        rsp_init.error_code = early_err;
    end

    ffpa_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (state_reg == S_DIVGO),
        .dividend(tot_c),
        .divisor (cnt_c),
        .busy    (div_busy),
        .quotient(part)
    );

    assign ix = i_reg[IW-1:0];

    logic cur_ok;
    assign cur_ok = i_reg < bcnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= 13'd64;
            mode_reg  <= 1'b1;
            count_reg <= 6'd1;
            state_reg <= S_DIVGO;
            bcnt_reg  <= '0;
            avail_reg <= 13'd0;
            used_reg  <= '0;
            done_reg  <= 1'b0;
            i_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we && cfg_index != 2'd3)
            begin
                unique case (cfg_index)
                    ffpa_pkg::CFG_TOTAL: total_reg <= cfg_data;
                    ffpa_pkg::CFG_MODE:  mode_reg  <= cfg_data[0];
                    ffpa_pkg::CFG_COUNT: count_reg <= cfg_data[5:0];
                    default:             ;
                endcase
                state_reg <= S_DIVGO;
            end
            else
            begin
                unique case (state_reg)
                    S_DIVGO: state_reg <= S_DIV;
                    S_DIV:
                    begin
                        if (!div_busy)
                        begin
                            avail_reg <= tot_c;
                            used_reg  <= '0;
                            i_reg     <= '0;
                            addr_reg  <= 13'd0;
                            if (mode_reg)
                            begin
                                st_reg[0] <= 12'd0;
                                sz_reg[0] <= tot_c;
                                bcnt_reg  <= CW'(1);
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                bcnt_reg  <= CW'(cnt_c);
                                state_reg <= S_BUILD;
                            end
                        end
                    end
                    S_BUILD:
                    begin
                        st_reg[ix] <= addr_reg[11:0];
                        sz_reg[ix] <= part;
                        addr_reg   <= addr_reg + part;
                        i_reg      <= i_reg + CW'(1);
                        if (i_reg + CW'(1) >= bcnt_reg)
                            state_reg <= S_IDLE;
                    end
                    S_IDLE:
                    begin
                        if (start)
                        begin
                            kind_reg <= req.req_type;
                            who_reg  <= ID_BITS'(req.owner_id);
                            want_reg <= req.req_size;
                            i_reg    <= '0;
                            n_reg    <= '0;
                            addr_reg <= 13'd0;
                            acc_reg  <= 13'd0;
                            rsp_reg  <= rsp_init;
                            if (early_err != ffpa_pkg::ERR_NONE)
                                state_reg <= S_DONE;
                            else if (req.req_type == ffpa_pkg::REQ_COMPACT)
                                state_reg <= S_COMP;
                            else
                                state_reg <= S_SCAN;
                        end
                    end
                    S_SCAN:
                    begin
                        // owner search for allocate and free, sum for query
                        if (!cur_ok)
                        begin
                            if (kind_reg == ffpa_pkg::REQ_ALLOC)
                            begin
                                i_reg     <= '0;
                                state_reg <= S_FIT;
                            end
                            else if (kind_reg == ffpa_pkg::REQ_FREE)
                            begin
                                rsp_reg.error_code <= ffpa_pkg::ERR_NOT_FND;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                rsp_reg.ok <= 1'b1;
                                if (mode_reg) rsp_reg.hole_total  <= acc_reg;
                                else          rsp_reg.waste_total <= acc_reg;
                                state_reg <= S_DONE;
                            end
                        end
                        else if (kind_reg == ffpa_pkg::REQ_QUERY)
                        begin
                            if (!mode_reg && used_reg[ix])
                                acc_reg <= acc_reg + ffpa_pkg::frag_of(sz_reg[ix]);
                            if (mode_reg && !used_reg[ix])
                                acc_reg <= acc_reg + sz_reg[ix];
                            i_reg <= i_reg + CW'(1);
                        end
                        else if (used_reg[ix] && own_reg[ix] == who_reg)
                        begin
                            if (kind_reg == ffpa_pkg::REQ_ALLOC)
                            begin
                                rsp_reg.error_code <= ffpa_pkg::ERR_DUP;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                used_reg[ix] <= 1'b0;
                                own_reg[ix]  <= '0;
                                avail_reg    <= avail_reg + sz_reg[ix];
                                rsp_reg.ok   <= 1'b1;
                                if (!mode_reg)
                                    state_reg <= S_DONE;
                                else if (i_reg + CW'(1) < bcnt_reg && !used_reg[ix+IW'(1)])
                                begin
                                    // absorb right neighbor then shift down
                                    sz_reg[ix] <= sz_reg[ix] + sz_reg[ix+IW'(1)];
                                    k_reg      <= i_reg;
                                    i_reg      <= i_reg + CW'(1);
                                    merge2_reg <= 1'b1;
                                    state_reg  <= S_RMV;
                                end
                                else
                                begin
                                    k_reg     <= i_reg;
                                    state_reg <= S_MERGE;
                                end
                            end
                        end
                        else
                            i_reg <= i_reg + CW'(1);
                    end
                    S_MERGE:
                    begin
                        // left neighbor merge of entry k
                        i_reg <= k_reg;
                        if (k_reg != '0 && !used_reg[IW'(k_reg - CW'(1))])
                        begin
                            sz_reg[IW'(k_reg - CW'(1))] <=
                                sz_reg[IW'(k_reg - CW'(1))] + sz_reg[k_reg[IW-1:0]];
                            merge2_reg <= 1'b0;
                            state_reg  <= S_RMV;
                        end
                        else
                            state_reg <= S_DONE;
                    end
                    S_RMV:
                    begin
                        // remove entry at i, one shift per cycle
                        if (i_reg + CW'(1) < bcnt_reg)
                        begin
                            st_reg[ix]   <= st_reg[ix+IW'(1)];
                            sz_reg[ix]   <= sz_reg[ix+IW'(1)];
                            used_reg[ix] <= used_reg[ix+IW'(1)];
                            own_reg[ix]  <= own_reg[ix+IW'(1)];
                            i_reg        <= i_reg + CW'(1);
                        end
                        else
                        begin
                            bcnt_reg <= bcnt_reg - CW'(1);
                            if (merge2_reg)
                            begin
                                merge2_reg <= 1'b0;
                                state_reg  <= S_MERGE;
                            end
                            else
                                state_reg <= S_DONE;
                        end
                    end
                    S_FIT:
                    begin
                        if (!cur_ok)
                        begin
                            rsp_reg.error_code <= ffpa_pkg::ERR_NO_FIT;
                            state_reg <= S_DONE;
                        end
                        else if (!used_reg[ix] && want_reg <= sz_reg[ix])
                        begin
                            if (!mode_reg || sz_reg[ix] == want_reg)
                            begin
                                used_reg[ix] <= 1'b1;
                                own_reg[ix]  <= who_reg;
                                avail_reg    <= avail_reg - (mode_reg ? want_reg : sz_reg[ix]);
                                rsp_reg.block_start <= st_reg[ix];
                                rsp_reg.ok   <= 1'b1;
                                state_reg    <= S_DONE;
                            end
                            else if ({{(32-CW){1'b0}}, bcnt_reg} >= MAX_BLOCKS)
                            begin
                                rsp_reg.error_code <= ffpa_pkg::ERR_FULL;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                k_reg     <= i_reg;
                                i_reg     <= bcnt_reg;
                                state_reg <= S_OPEN;
                            end
                        end
                        else
                            i_reg <= i_reg + CW'(1);
                    end
                    S_OPEN:
                    begin
                        // shift up from the end down to k, then split
                        if (i_reg > k_reg)
                        begin
                            st_reg[ix]   <= st_reg[ix-IW'(1)];
                            sz_reg[ix]   <= sz_reg[ix-IW'(1)];
                            used_reg[ix] <= used_reg[ix-IW'(1)];
                            own_reg[ix]  <= own_reg[ix-IW'(1)];
                            i_reg        <= i_reg - CW'(1);
                        end
                        else
                        begin
                            sz_reg[ix]   <= want_reg;
                            used_reg[ix] <= 1'b1;
                            own_reg[ix]  <= who_reg;
                            st_reg[ix+IW'(1)] <= st_reg[ix] + want_reg[11:0];
                            sz_reg[ix+IW'(1)] <= sz_reg[ix] - want_reg;
                            bcnt_reg     <= bcnt_reg + CW'(1);
                            avail_reg    <= avail_reg - want_reg;
                            rsp_reg.block_start <= st_reg[ix];
                            rsp_reg.ok   <= 1'b1;
                            state_reg    <= S_DONE;
                        end
                    end
                    S_COMP:
                    begin
                        // n trails i; occupied entries move down
                        if (cur_ok)
                        begin
                            if (used_reg[ix])
                            begin
                                st_reg[n_reg[IW-1:0]]   <= addr_reg[11:0];
                                sz_reg[n_reg[IW-1:0]]   <= sz_reg[ix];
                                used_reg[n_reg[IW-1:0]] <= 1'b1;
                                own_reg[n_reg[IW-1:0]]  <= own_reg[ix];
                                addr_reg <= addr_reg + sz_reg[ix];
                                n_reg    <= n_reg + CW'(1);
                            end
                            i_reg <= i_reg + CW'(1);
                        end
                        else
                        begin
                            if (avail_reg != 13'd0 && {{(32-CW){1'b0}}, n_reg} < MAX_BLOCKS)
                            begin
                                st_reg[n_reg[IW-1:0]]   <= addr_reg[11:0];
                                sz_reg[n_reg[IW-1:0]]   <= avail_reg;
                                used_reg[n_reg[IW-1:0]] <= 1'b0;
                                own_reg[n_reg[IW-1:0]]  <= '0;
                                bcnt_reg <= n_reg + CW'(1);
                            end
                            else
                                bcnt_reg <= n_reg;
                            rsp_reg.ok <= 1'b1;
                            state_reg  <= S_DONE;
                        end
                    end
                    S_DONE:
                    begin
                        rsp_reg.free_total <= avail_reg;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef NO_ASSERTIONS
    // a result only follows the finishing state
    a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == S_DONE)
        else $error("result without finishing state");

    // the table never holds more than MAX_BLOCKS entries
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {{(32-CW){1'b0}}, bcnt_reg} <= MAX_BLOCKS)
        else $error("block count overflow");

    // a success never carries an error code
    a_ok_no_err: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.ok |-> rsp.error_code == ffpa_pkg::ERR_NONE)
        else $error("ok with error code");
`endif
endmodule

// ===== tb/first_fit_partition_allocator_test.sv =====
// self-checking testbench for first_fit_partition_allocator
// depends on ffpa_pkg and the allocator rtl; predicts every response in place
`timescale 1ns / 1ps

module first_fit_partition_allocator_test;

    localparam int NBLK = 32;
    localparam int LIMIT = 2000000;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    ffpa_pkg::req_t req;
    logic           done;
    ffpa_pkg::rsp_t rsp;
    logic           cfg_we;
    logic [1:0]     cfg_index;
    logic [12:0]    cfg_data;

    first_fit_partition_allocator u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow of the allocator: configuration and block table
    logic [12:0] sh_total;
    logic        sh_dynamic;
    logic [5:0]  sh_count;
    logic [12:0] b_start [NBLK];
    logic [12:0] b_size [NBLK];
    logic        b_used [NBLK];
    logic [7:0]  b_owner [NBLK];
    int          n_blocks;
    logic [12:0] avail_units;

    ffpa_pkg::rsp_t pending_rsp [$];
    logic           pending_known [$];
    ffpa_pkg::rsp_t typed_rsp [$];
    int             errors;
    int             cycle_count;
    int             idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // rebuild the table after any configuration write
    function automatic void rebuild_table();
        int tot;
        int cnt;
        int psz;
        begin
            tot = sh_total;
            cnt = sh_count;
            if (tot == 0) tot = 1;
            if (tot > 4096) tot = 4096;
            if (cnt == 0) cnt = 1;
            if (cnt > NBLK) cnt = NBLK;
            for (int i = 0; i < NBLK; i++)
            begin
                b_start[i] = '0; b_size[i] = '0; b_used[i] = 1'b0; b_owner[i] = '0;
            end
            avail_units = 13'(tot);
            psz = tot / cnt;
            if (!sh_dynamic)
            begin
                for (int i = 0; i < cnt; i++)
                begin
                    b_start[i] = 13'(i * psz);
                    b_size[i] = 13'(psz);
                end
                n_blocks = cnt;
            end
            else
            begin
                b_size[0] = 13'(tot);
                n_blocks = 1;
            end
        end
    endfunction

    function automatic void drop_entry(int k);
        begin
            for (int i = k; i + 1 < n_blocks; i++)
            begin
                b_start[i] = b_start[i+1]; b_size[i] = b_size[i+1];
                b_used[i] = b_used[i+1]; b_owner[i] = b_owner[i+1];
            end
            n_blocks--;
        end
    endfunction

    function automatic int owner_slot(logic [7:0] who);
        begin
            for (int i = 0; i < n_blocks; i++)
                if (b_used[i] && b_owner[i] == who) return i;
            return -1;
        end
    endfunction

    // work out the response of one request and update the shadow table
    function automatic ffpa_pkg::rsp_t serve_request(ffpa_pkg::req_t r);
        ffpa_pkg::rsp_t o;
        int   i;
        int   n;
        int   addr;
        begin
            o = '0;
            case (r.req_type)
                ffpa_pkg::REQ_ALLOC:
                begin
                    if (r.req_size == 0) o.error_code = ffpa_pkg::ERR_BAD_SIZE;
                    else if (r.req_size > avail_units) o.error_code = ffpa_pkg::ERR_SHORT;
                    else if (owner_slot(r.owner_id) >= 0) o.error_code = ffpa_pkg::ERR_DUP;
                    else
                    begin
                        for (i = 0; i < n_blocks; i++)
                            if (!b_used[i] && r.req_size <= b_size[i]) break;
                        if (i >= n_blocks) o.error_code = ffpa_pkg::ERR_NO_FIT;
                        else if (!sh_dynamic || b_size[i] == r.req_size)
                        begin
                            b_used[i] = 1'b1;
                            b_owner[i] = r.owner_id;
                            avail_units -= sh_dynamic ? r.req_size : b_size[i];
                            o.block_start = 12'(b_start[i]);
                            o.ok = 1'b1;
                        end
                        else if (n_blocks >= NBLK) o.error_code = ffpa_pkg::ERR_FULL;
                        else
                        begin
                            // open a slot and split the free block
                            for (int j = n_blocks; j > i; j--)
                            begin
                                b_start[j] = b_start[j-1]; b_size[j] = b_size[j-1];
                                b_used[j] = b_used[j-1]; b_owner[j] = b_owner[j-1];
                            end
                            n_blocks++;
                            b_size[i] = r.req_size;
                            b_used[i] = 1'b1;
                            b_owner[i] = r.owner_id;
                            b_start[i+1] = b_start[i+1] + r.req_size;
                            b_size[i+1] = b_size[i+1] - r.req_size;
                            avail_units -= r.req_size;
                            o.block_start = 12'(b_start[i]);
                            o.ok = 1'b1;
                        end
                    end
                end
                ffpa_pkg::REQ_FREE:
                begin
                    i = owner_slot(r.owner_id);
                    if (i < 0) o.error_code = ffpa_pkg::ERR_NOT_FND;
                    else
                    begin
                        b_used[i] = 1'b0;
                        b_owner[i] = '0;
                        avail_units += b_size[i];
                        if (sh_dynamic)
                        begin
                            if (i + 1 < n_blocks && !b_used[i+1])
                            begin
                                b_size[i] = b_size[i] + b_size[i+1];
                                drop_entry(i + 1);
                            end
                            if (i > 0 && !b_used[i-1])
                            begin
                                b_size[i-1] = b_size[i-1] + b_size[i];
                                drop_entry(i);
                            end
                        end
                        o.ok = 1'b1;
                    end
                end
                ffpa_pkg::REQ_COMPACT:
                begin
                    if (!sh_dynamic) o.error_code = ffpa_pkg::ERR_FIXED;
                    else
                    begin
                        n = 0;
                        addr = 0;
                        for (i = 0; i < n_blocks; i++)
                            if (b_used[i])
                            begin
                                b_start[n] = 13'(addr);
                                b_size[n] = b_size[i];
                                b_used[n] = 1'b1;
                                b_owner[n] = b_owner[i];
                                addr += b_size[i];
                                n++;
                            end
                        if (avail_units > 0 && n < NBLK)
                        begin
                            b_start[n] = 13'(addr);
                            b_size[n] = avail_units;
                            b_used[n] = 1'b0;
                            b_owner[n] = '0;
                            n++;
                        end
                        n_blocks = n;
                        o.ok = 1'b1;
                    end
                end
                default:
                begin
                    for (i = 0; i < n_blocks; i++)
                    begin
                        if (!sh_dynamic && b_used[i])
                            o.waste_total += b_size[i] - 13'((b_size[i] * 7) / 10);
                        if (sh_dynamic && !b_used[i])
                            o.hole_total += b_size[i];
                    end
                    o.ok = 1'b1;
                end
            endcase
            o.free_total = avail_units;
            return o;
        end
    endfunction

    // wait until the block is free, then issue one request
    task automatic send_request(ffpa_pkg::req_t r, logic typed, ffpa_pkg::rsp_t typed_val);
        ffpa_pkg::rsp_t p;
        begin
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
            start <= 1'b1;
            req <= r;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            // accepted at this edge
            p = serve_request(r);
            pending_rsp.push_back(p);
            pending_known.push_back(typed);
            typed_rsp.push_back(typed_val);
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        begin
            while (pending_rsp.size() != 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
    endtask

    // idle-only register write; waits for the table rebuild to finish
    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        begin
            drain();
            cfg_we <= 1'b1;
            cfg_index <= idx;
            cfg_data <= val;
            @(posedge clk);
            cfg_we <= 1'b0;
            case (idx)
                ffpa_pkg::CFG_TOTAL: sh_total = val;
                ffpa_pkg::CFG_MODE:  sh_dynamic = val[0];
                default:             sh_count = val[5:0];
            endcase
            rebuild_table();
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    // response checker: oldest prediction against each strobe
    always @(posedge clk)
    begin
        ffpa_pkg::rsp_t e;
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with no request outstanding");
                errors++;
            end
            else
            begin
                e = pending_rsp.pop_front();
                if (pending_known.pop_front() && typed_rsp[0] !== e)
                begin
                    $error("typed row disagrees with predictor");
                    errors++;
                end
                void'(typed_rsp.pop_front());
                if (rsp.ok !== e.ok)
                begin
                    $error("ok exp %0d got %0d", e.ok, rsp.ok); errors++;
                end
                if (rsp.error_code !== e.error_code)
                begin
                    $error("error_code exp %0d got %0d", e.error_code, rsp.error_code);
                    errors++;
                end
                if (rsp.block_start !== e.block_start)
                begin
                    $error("block_start exp %0d got %0d", e.block_start, rsp.block_start);
                    errors++;
                end
                if (rsp.waste_total !== e.waste_total)
                begin
                    $error("waste_total exp %0d got %0d", e.waste_total,
                        rsp.waste_total);
                    errors++;
                end
                if (rsp.hole_total !== e.hole_total)
                begin
                    $error("hole_total exp %0d got %0d", e.hole_total,
                        rsp.hole_total);
                    errors++;
                end
                if (rsp.free_total !== e.free_total)
                begin
                    $error("free_total exp %0d got %0d", e.free_total, rsp.free_total);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("first_fit_partition_allocator_test: errors");
            $finish;
        end
    end

    // directed rows: request plus a typed response where it is obvious
    typedef struct {
        ffpa_pkg::req_t r;
        logic           typed;
        ffpa_pkg::rsp_t val;
    } dir_row_t;

    function automatic ffpa_pkg::rsp_t mk(logic ok, logic [2:0] ec, logic [11:0] bs,
                                          logic [12:0] ht, logic [12:0] ft);
        ffpa_pkg::rsp_t o;
        begin
            o = '0;
            o.ok = ok; o.error_code = ec; o.block_start = bs;
            o.hole_total = ht; o.free_total = ft;
            return o;
        end
    endfunction

    // a random request, mostly well-formed with live owners
    function automatic ffpa_pkg::req_t rand_req();
        ffpa_pkg::req_t r;
        int   k;
        begin
            k = $urandom_range(99);
            r.owner_id = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(7));
            if (k < 45) r.req_type = ffpa_pkg::REQ_ALLOC;
            else if (k < 80) r.req_type = ffpa_pkg::REQ_FREE;
            else if (k < 90) r.req_type = ffpa_pkg::REQ_COMPACT;
            else r.req_type = ffpa_pkg::REQ_QUERY;
            case ($urandom_range(9))
                0: r.req_size = 13'($urandom);
                1: r.req_size = 13'($urandom_range(4096));
                2: r.req_size = '0;
                default: r.req_size = 13'($urandom_range(1, (sh_total >> 3) + 1));
            endcase
            return r;
        end
    endfunction

    initial
    begin
        dir_row_t rows [$];
        dir_row_t row;
        logic [12:0] totals [6];
        logic [5:0]  counts [6];

        errors = 0;
        cycle_count = 0;
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        cfg_we = 1'b0;
        cfg_index = ffpa_pkg::CFG_TOTAL;
        cfg_data = '0;
        sh_total = 13'd64;
        sh_dynamic = 1'b1;
        sh_count = 6'd1;
        rebuild_table();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // directed, reset state: 64 free units, dynamic mode
        rows = '{
            '{'{ffpa_pkg::REQ_QUERY, 8'd0, 13'd0}, 1'b1,
              mk(1'b1, ffpa_pkg::ERR_NONE, 12'd0, 13'd64, 13'd64)},
            '{'{ffpa_pkg::REQ_ALLOC, 8'd1, 13'd0}, 1'b1,
              mk(1'b0, ffpa_pkg::ERR_BAD_SIZE, 12'd0, 13'd0, 13'd64)},
            '{'{ffpa_pkg::REQ_ALLOC, 8'd1, 13'h1FFF}, 1'b1,
              mk(1'b0, ffpa_pkg::ERR_SHORT, 12'd0, 13'd0, 13'd64)},
            '{'{ffpa_pkg::REQ_ALLOC, 8'd1, 13'd65}, 1'b1,
              mk(1'b0, ffpa_pkg::ERR_SHORT, 12'd0, 13'd0, 13'd64)},
            '{'{ffpa_pkg::REQ_ALLOC, 8'd1, 13'd10}, 1'b1,
              mk(1'b1, ffpa_pkg::ERR_NONE, 12'd0, 13'd0, 13'd54)},
            '{'{ffpa_pkg::REQ_ALLOC, 8'd1, 13'd5}, 1'b1,
              mk(1'b0, ffpa_pkg::ERR_DUP, 12'd0, 13'd0, 13'd54)},
            '{'{ffpa_pkg::REQ_ALLOC, 8'd255, 13'd20}, 1'b1,
              mk(1'b1, ffpa_pkg::ERR_NONE, 12'd10, 13'd0, 13'd34)},
            '{'{ffpa_pkg::REQ_ALLOC, 8'd2, 13'd34}, 1'b1,
              mk(1'b1, ffpa_pkg::ERR_NONE, 12'd30, 13'd0, 13'd0)},
            '{'{ffpa_pkg::REQ_FREE, 8'd1, 13'd0}, 1'b1,
              mk(1'b1, ffpa_pkg::ERR_NONE, 12'd0, 13'd0, 13'd10)},
            '{'{ffpa_pkg::REQ_FREE, 8'd9, 13'd0}, 1'b1,
              mk(1'b0, ffpa_pkg::ERR_NOT_FND, 12'd0, 13'd0, 13'd10)},
            '{'{ffpa_pkg::REQ_FREE, 8'd2, 13'd0}, 1'b1,
              mk(1'b1, ffpa_pkg::ERR_NONE, 12'd0, 13'd0, 13'd44)},
            '{'{ffpa_pkg::REQ_ALLOC, 8'd3, 13'd40}, 1'b1,
              mk(1'b0, ffpa_pkg::ERR_NO_FIT, 12'd0, 13'd0, 13'd44)},
            '{'{ffpa_pkg::REQ_COMPACT, 8'hAA, 13'h1555}, 1'b0, '0},
            '{'{ffpa_pkg::REQ_ALLOC, 8'd3, 13'd44}, 1'b0, '0},
            '{'{ffpa_pkg::REQ_QUERY, 8'h55, 13'h0AAA}, 1'b0, '0},
            '{'{ffpa_pkg::REQ_FREE, 8'd255, 13'd0}, 1'b0, '0},
            '{'{ffpa_pkg::REQ_FREE, 8'd3, 13'd0}, 1'b0, '0}
        };
        foreach (rows[i])
            send_request(rows[i].r, rows[i].typed, rows[i].val);

        // table full: 31 one-unit splits fill the table, then further splits
        write_reg(ffpa_pkg::CFG_TOTAL, 13'd4096);
        for (int i = 0; i < 33; i++)
        begin
            row.r = '{ffpa_pkg::REQ_ALLOC, 8'(i), 13'd1};
            send_request(row.r, 1'b0, '0);
        end
        send_request('{ffpa_pkg::REQ_FREE, 8'd5, 13'd0}, 1'b0, '0);
        send_request('{ffpa_pkg::REQ_COMPACT, 8'd0, 13'd0}, 1'b0, '0);

        // fixed mode: compact error, tiny partitions, query
        write_reg(ffpa_pkg::CFG_MODE, 13'd0);
        write_reg(ffpa_pkg::CFG_COUNT, 13'd32);
        send_request('{ffpa_pkg::REQ_COMPACT, 8'd0, 13'd0}, 1'b1,
            mk(1'b0, ffpa_pkg::ERR_FIXED, 12'd0, 13'd0, 13'd4096));
        send_request('{ffpa_pkg::REQ_ALLOC, 8'd7, 13'd100}, 1'b1,
            mk(1'b1, ffpa_pkg::ERR_NONE, 12'd0, 13'd0, 13'd3968));
        send_request('{ffpa_pkg::REQ_QUERY, 8'd0, 13'd0}, 1'b0, '0);
        write_reg(ffpa_pkg::CFG_TOTAL, 13'd5);
        send_request('{ffpa_pkg::REQ_ALLOC, 8'd1, 13'd1}, 1'b1,
            mk(1'b0, ffpa_pkg::ERR_NO_FIT, 12'd0, 13'd0, 13'd5));
        write_reg(ffpa_pkg::CFG_COUNT, 13'd0);
        send_request('{ffpa_pkg::REQ_ALLOC, 8'd1, 13'd1}, 1'b1,
            mk(1'b1, ffpa_pkg::ERR_NONE, 12'd0, 13'd0, 13'd0));
        write_reg(ffpa_pkg::CFG_TOTAL, 13'd0);
        write_reg(ffpa_pkg::CFG_COUNT, 13'h1FFF);
        write_reg(ffpa_pkg::CFG_TOTAL, 13'h1FFF);

        // random phases over a spread of settings and idle rates
        totals = '{13'd64, 13'd1, 13'd4096, 13'd100, 13'd777, 13'd32};
        counts = '{6'd1, 6'd32, 6'd7, 6'd4, 6'd63, 6'd3};
        for (int ph = 0; ph < 12; ph++)
        begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 58;
                2: idle_pct = 0;
                default: idle_pct = 35;
            endcase
            write_reg(ffpa_pkg::CFG_MODE, 13'(ph % 3 != 0));
            write_reg(ffpa_pkg::CFG_TOTAL, totals[ph % 6]);
            write_reg(ffpa_pkg::CFG_COUNT, 13'(counts[(ph + 1) % 6]));
            for (int i = 0; i < 50; i++)
                send_request(rand_req(), 1'b0, '0);
        end

        drain();
        if (errors == 0)
            $display("first_fit_partition_allocator_test: clean");
        else
            $display("first_fit_partition_allocator_test: errors");
        $finish;
    end

endmodule

// ===== first_fit_partition_allocator.f =====
hdl/ffpa_pkg.sv
hdl/ffpa_div.sv
hdl/first_fit_partition_allocator.sv
tb/first_fit_partition_allocator_test.sv
